>>> rtl/rmf_pkg.sv
// Shared types and constants for the 5x5 RGB median filter.
// Used by rmf_median and the top level; no dependencies.
`timescale 1ns / 1ps

package rmf_pkg;

  // default storage limits
  localparam int DEF_MAX_PADDED_WIDTH  = 2048;
  localparam int DEF_MAX_PADDED_HEIGHT = 4096;

  // pixel layout: red in [7:0], green in [15:8], blue in [23:16]
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;
  localparam int PIX_W     = CH_W * NUM_CH;
  localparam int NUM_TAPS  = 25;
  localparam int MED_RANK  = 12;
  localparam int ROW_SLOTS = 4;

  // configuration register widths
  localparam int PW_W  = 12;
  localparam int IW_W  = 11;
  localparam int IH_W  = 12;
  localparam int ROW_W = 12;

  // register index codes (paddr[3:2])
  localparam logic [1:0] REG_PADDED_WIDTH = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef pixel_t [NUM_TAPS-1:0] window_t;
  typedef pixel_t [ROW_SLOTS-1:0] row_word_t;

  // control that travels with one window word
  typedef struct packed {
    logic vld;
    logic frame_done;
  } rmf_ctl_t;

endpackage

>>> rtl/rmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`timescale 1ns / 1ps

module rmf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     ren,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/rmf_median.sv
// Two-stage exact 25-input median for three channels: rank compares, then select.
// Depends on rmf_pkg.
`timescale 1ns / 1ps

module rmf_median (
  input  logic              clk,
  input  logic              rst,
  input  rmf_pkg::rmf_ctl_t in_ctl,
  input  rmf_pkg::window_t  window,
  output logic              in_stall,
  output rmf_pkg::rmf_ctl_t out_ctl,
  output rmf_pkg::pixel_t   median,
  input  logic              out_stall
);

  logic [rmf_pkg::NUM_CH-1:0][rmf_pkg::NUM_TAPS-1:0][rmf_pkg::NUM_TAPS-1:0] less;
  logic [rmf_pkg::NUM_CH-1:0][rmf_pkg::NUM_TAPS-1:0][rmf_pkg::NUM_TAPS-1:0] less_next;
  rmf_pkg::window_t vals;
  logic             vld_c;
  logic             done_c;
  logic             vld_o;
  logic             done_o;
  rmf_pkg::pixel_t  med_next;
  logic             o_load;
  logic             c_load;

  assign o_load   = !vld_o || !out_stall;
  assign c_load   = !vld_c || o_load;
  assign in_stall = vld_c && !o_load;

  // strict order with index tie-break gives every tap a unique rank
  always_comb begin
    less_next = '0;
    for (int ch = 0; ch < rmf_pkg::NUM_CH; ch++) begin
      for (int i = 0; i < rmf_pkg::NUM_TAPS; i++) begin
        for (int j = 0; j < rmf_pkg::NUM_TAPS; j++) begin
          if (j < i) begin
            less_next[ch][i][j] = window[j][ch*rmf_pkg::CH_W +: rmf_pkg::CH_W] <=
                                  window[i][ch*rmf_pkg::CH_W +: rmf_pkg::CH_W];
          end else if (j > i) begin
            less_next[ch][i][j] = window[j][ch*rmf_pkg::CH_W +: rmf_pkg::CH_W] <
                                  window[i][ch*rmf_pkg::CH_W +: rmf_pkg::CH_W];
          end
        end
      end
    end
  end

  // compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_c <= 1'b0;
    end else if (c_load) begin
      vld_c <= in_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (c_load) begin
      less   <= less_next;
      vals   <= window;
      done_c <= in_ctl.frame_done;
    end
  end

  // pick the tap of rank twelve in each channel
  always_comb begin
    med_next = '0;
    for (int ch = 0; ch < rmf_pkg::NUM_CH; ch++) begin
      for (int i = 0; i < rmf_pkg::NUM_TAPS; i++) begin
        if ($countones(less[ch][i]) == rmf_pkg::MED_RANK) begin
          med_next[ch*rmf_pkg::CH_W +: rmf_pkg::CH_W] =
            med_next[ch*rmf_pkg::CH_W +: rmf_pkg::CH_W] |
            vals[i][ch*rmf_pkg::CH_W +: rmf_pkg::CH_W];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_o <= 1'b0;
    end else if (o_load) begin
      vld_o <= vld_c;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      median <= med_next;
      done_o <= done_c;
    end
  end

  assign out_ctl.vld        = vld_o;
  assign out_ctl.frame_done = done_o;

endmodule

>>> rtl/rgb_median_filter_5x5.sv
// Top level of the 5x5 RGB median filter: APB registers, raster counters,
// line store read-modify-write, window register. Uses rmf_pkg, rmf_ram, rmf_median.
//
// channel | direction | handshake          | payload
// --------+-----------+--------------------+-------------------------------------
// in      | input     | in_valid/in_stall  | in_red, in_green, in_blue
// out     | output    | out_valid/out_stall| median_red/green/blue, frame_done
// cfg     | input     | psel/penable/pwrite| paddr, pwdata, prdata, pready
//
// One word per cycle sustained while out_stall is low; a result passes the line
// store read, window, rank compare and select registers. The line store is one
// column-wide RAM read at accept and written back as the word leaves that stage,
// with the last write forwarded. Reset is synchronous and needs no clearing pass.
// A stalled output fills the internal stages before in_stall rises.
`timescale 1ns / 1ps

module rgb_median_filter_5x5 #(
  parameter int MAX_PADDED_WIDTH  = rmf_pkg::DEF_MAX_PADDED_WIDTH,
  parameter int MAX_PADDED_HEIGHT = rmf_pkg::DEF_MAX_PADDED_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  median_red,
  output logic [7:0]  median_green,
  output logic [7:0]  median_blue,
  output logic        frame_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW    = $clog2(MAX_PADDED_WIDTH);
  localparam int CNTW  = $clog2(MAX_PADDED_WIDTH + 1);
  localparam int PWCW  = (CNTW > rmf_pkg::PW_W) ? CNTW : rmf_pkg::PW_W;
  localparam int PHW0  = $clog2(MAX_PADDED_HEIGHT + 1);
  localparam int PHW   = (PHW0 > rmf_pkg::IH_W + 1) ? PHW0 : rmf_pkg::IH_W + 1;
  localparam int XW    = (AW > rmf_pkg::IW_W) ? AW : rmf_pkg::IW_W;
  localparam int LW    = (CNTW > rmf_pkg::IW_W + 1) ? CNTW : rmf_pkg::IW_W + 1;

  // configuration registers
  logic [rmf_pkg::PW_W-1:0] padded_width;
  logic [rmf_pkg::IW_W-1:0] image_width;
  logic [rmf_pkg::IH_W-1:0] image_height;
  logic                     cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      padded_width <= rmf_pkg::PW_W'(644);
      image_width  <= rmf_pkg::IW_W'(640);
      image_height <= rmf_pkg::IH_W'(480);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        rmf_pkg::REG_PADDED_WIDTH: padded_width <= pwdata[rmf_pkg::PW_W-1:0];
        rmf_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[rmf_pkg::IW_W-1:0];
        rmf_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[rmf_pkg::IH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rmf_pkg::REG_PADDED_WIDTH: prdata = 32'(padded_width);
      rmf_pkg::REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      rmf_pkg::REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:                   prdata = '0;
    endcase
  end

  // raster position of the next word
  logic [AW-1:0]           column_count;
  logic [rmf_pkg::ROW_W-1:0] row_count;
  logic [CNTW-1:0]         pw_eff;
  logic [PWCW-1:0]         pw_wide;
  logic [PWCW-1:0]         pw_max;
  logic [PHW-1:0]          ph;
  logic [PHW-1:0]          h_plus4;
  logic [PHW-1:0]          h_max;
  logic [CNTW-1:0]         col_inc;
  logic [rmf_pkg::ROW_W:0] row_inc;
  logic                    col_wrap;
  logic                    row_wrap;
  logic                    col_ok;
  logic                    row_ok;
  logic                    has_result;
  logic [LW-1:0]           lc_img;
  logic [LW-1:0]           lc_pw;
  logic [LW-1:0]           last_col;
  logic                    is_last;
  logic                    accept;

  assign pw_wide  = PWCW'(padded_width);
  assign pw_max   = PWCW'(MAX_PADDED_WIDTH);
  assign pw_eff   = (pw_wide > pw_max) ? CNTW'(pw_max) : CNTW'(pw_wide);
  assign h_plus4  = PHW'({1'b0, image_height} + (rmf_pkg::IH_W + 1)'(4));
  assign h_max    = PHW'(MAX_PADDED_HEIGHT);
  assign ph       = (h_plus4 > h_max) ? h_max : h_plus4;
  assign col_inc  = CNTW'(column_count) + CNTW'(1);
  assign row_inc  = {1'b0, row_count} + (rmf_pkg::ROW_W + 1)'(1);
  assign col_wrap = col_inc >= pw_eff;
  assign row_wrap = PHW'(row_inc) >= ph;

  // window inside the output image
  assign col_ok = (XW'(column_count) >= XW'(4)) &&
                  ((XW'(column_count) - XW'(4)) < XW'(image_width));
  assign row_ok = (row_count >= rmf_pkg::ROW_W'(4)) &&
                  ((row_count - rmf_pkg::ROW_W'(4)) < image_height);
  assign has_result = col_ok && row_ok;

  assign lc_img   = LW'(image_width) + LW'(4);
  assign lc_pw    = LW'(pw_eff);
  assign last_col = (lc_img > lc_pw) ? lc_pw : lc_img;
  assign is_last  = (PHW'(row_inc) == ph) && (LW'(col_inc) == last_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_inc[rmf_pkg::ROW_W-1:0];
      end else begin
        column_count <= col_inc[AW-1:0];
      end
    end
  end

  // line store stage
  logic                vld_s1;
  rmf_pkg::pixel_t     pix_s1;
  logic [AW-1:0]       col_s1;
  logic [1:0]          slot_s1;
  logic                res_s1;
  logic                done_s1;
  logic                s1_fire;
  logic                w_load;
  rmf_pkg::row_word_t  ram_rdata;
  rmf_pkg::row_word_t  rd_word;
  rmf_pkg::row_word_t  wr_word;
  logic                wr_last_vld;
  logic [AW-1:0]       wr_last_addr;
  rmf_pkg::row_word_t  wr_last_data;
  rmf_pkg::pixel_t     col_pix [rmf_pkg::ROW_SLOTS];

  assign in_stall = vld_s1 && !w_load;
  assign accept   = in_valid && !in_stall;
  assign s1_fire  = vld_s1 && w_load;

  rmf_ram #(
    .WIDTH ($bits(rmf_pkg::row_word_t)),
    .DEPTH (MAX_PADDED_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .wen   (s1_fire),
    .waddr (col_s1),
    .wdata (wr_word),
    .ren   (accept),
    .raddr (column_count),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s1 <= 1'b0;
    end else if (!vld_s1 || w_load) begin
      vld_s1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_s1  <= {in_blue, in_green, in_red};
      col_s1  <= column_count;
      slot_s1 <= row_count[1:0];
      res_s1  <= has_result;
      done_s1 <= is_last;
    end
  end

  // forward the write that landed with this word's read
  assign rd_word = (wr_last_vld && (wr_last_addr == col_s1)) ? wr_last_data : ram_rdata;

  always_comb begin
    wr_word          = rd_word;
    wr_word[slot_s1] = pix_s1;
    for (int k = 0; k < rmf_pkg::ROW_SLOTS; k++) begin
      col_pix[k] = rd_word[slot_s1 + 2'(k)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_last_vld <= 1'b0;
    end else if (s1_fire) begin
      wr_last_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      wr_last_addr <= col_s1;
      wr_last_data <= wr_word;
    end
  end

  // window register: five columns of five rows, newest column on top
  rmf_pkg::window_t  window;
  rmf_pkg::window_t  window_next;
  logic              vld_w;
  logic              done_w;
  logic              med_stall;
  rmf_pkg::rmf_ctl_t med_in_ctl;
  rmf_pkg::rmf_ctl_t med_out_ctl;
  rmf_pkg::pixel_t   median;

  always_comb begin
    for (int i = 0; i < rmf_pkg::NUM_TAPS - 5; i++) begin
      window_next[i] = window[i + 5];
    end
    for (int k = 0; k < rmf_pkg::ROW_SLOTS; k++) begin
      window_next[rmf_pkg::NUM_TAPS - 5 + k] = col_pix[k];
    end
    window_next[rmf_pkg::NUM_TAPS - 1] = pix_s1;
  end

  assign w_load = !vld_w || !med_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_w <= 1'b0;
    end else if (s1_fire) begin
      vld_w <= res_s1;
    end else if (w_load) begin
      vld_w <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      window <= window_next;
      done_w <= done_s1;
    end
  end

  assign med_in_ctl.vld        = vld_w;
  assign med_in_ctl.frame_done = done_w;

  rmf_median u_median (
    .clk       (clk),
    .rst       (rst),
    .in_ctl    (med_in_ctl),
    .window    (window),
    .in_stall  (med_stall),
    .out_ctl   (med_out_ctl),
    .median    (median),
    .out_stall (out_stall)
  );

  assign out_valid    = med_out_ctl.vld;
  assign frame_done   = med_out_ctl.frame_done;
  assign median_red   = median[7:0];
  assign median_green = median[15:8];
  assign median_blue  = median[23:16];

`ifndef SYNTHESIS
  // an accepted word always lands in the line store stage
  a_accept_to_s1: assert property (@(posedge clk) disable iff (rst)
    accept |=> vld_s1)
    else $error("accepted word missing from line store stage");

  // input stalls only behind a held line store word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (vld_s1 && vld_w && med_stall))
    else $error("input stall without a full window stage");

  // column position stays inside the line store
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    CNTW'(column_count) < CNTW'(MAX_PADDED_WIDTH))
    else $error("column count beyond line store depth");
`endif

endmodule
